// ===== rtl/lsqm_pkg.sv =====
// ----------------------------------------------------------------------------
// lsqm_pkg
// Shared types, constants and helpers for the linked slot queue manager:
// item structs, operation codes, controller states and link encoding.
// ----------------------------------------------------------------------------
package lsqm_pkg;

    // Pool size and derived widths
    localparam int SLOTS  = 64;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int LINK_W = IDX_W + 1;
    localparam int SLOT_W = 6;

    // End of list marker; all ones is always at or above SLOTS
    localparam logic [LINK_W-1:0] END_LINK = {LINK_W{1'b1}};

    // Operation codes
    typedef enum logic [1:0] {
        FUNC_ACQUIRE = 2'd0,
        FUNC_COMMIT  = 2'd1,
        FUNC_PEEK    = 2'd2,
        FUNC_RELEASE = 2'd3
    } func_t;

    // Request item
    typedef struct packed {
        func_t             func;
        logic [SLOT_W-1:0] slot;
    } in_item_t;

    // Response item
    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic              valid_res;
    } out_item_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

    // Any link value at or above the pool size means end of list
    function automatic logic is_end(input logic [LINK_W-1:0] v);
        return v >= LINK_W'(SLOTS);
    endfunction

    // Link contents after reset: each entry points to the next, last is end
    function automatic logic [LINK_W-1:0] reset_link(input logic [IDX_W-1:0] idx);
        logic [LINK_W-1:0] succ;
        succ = LINK_W'(idx) + LINK_W'(1);
        return (succ < LINK_W'(SLOTS)) ? succ : END_LINK;
    endfunction

endpackage

// ===== rtl/lsqm_ram.sv =====
// ----------------------------------------------------------------------------
// lsqm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lsqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lsqm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsqm_ctrl
// Controller: takes one request item, waits for the registered link read,
// then commits the update once the response register is free.
// ----------------------------------------------------------------------------
module lsqm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output lsqm_pkg::cmd_t cmd
);

    lsqm_pkg::state_t state_reg;
    lsqm_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // State and response valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsqm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            lsqm_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = lsqm_pkg::ST_EXEC;
                end
            end
            lsqm_pkg::ST_EXEC:
            begin
                // Advance only when the response register drains or is empty
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.execute = 1'b1;
                    state_next  = lsqm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsqm_pkg::ST_IDLE;
            end
        endcase

        // Load on execute, drop when taken, hold otherwise
        priority if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

// ===== rtl/lsqm_datapath.sv =====
// ----------------------------------------------------------------------------
// lsqm_datapath
// Link memory, list head and tail registers, and response register.
// Reads one link entry on capture and writes at most one back on execute.
// ----------------------------------------------------------------------------
module lsqm_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  lsqm_pkg::cmd_t      cmd,
    input  lsqm_pkg::in_item_t  req,
    output lsqm_pkg::out_item_t rsp
);

    localparam int IDX_W  = lsqm_pkg::IDX_W;
    localparam int LINK_W = lsqm_pkg::LINK_W;
    localparam int SLOTS  = lsqm_pkg::SLOTS;

    // List pointers and per entry written flags
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] queue_head_reg, queue_head_next;
    logic [LINK_W-1:0] queue_tail_reg, queue_tail_next;
    logic [SLOTS-1:0]  vld_reg, vld_next;

    // Captured item and read context
    lsqm_pkg::in_item_t  item_reg;
    logic [IDX_W-1:0]    rd_addr_reg;
    logic                rd_vld_reg;
    lsqm_pkg::out_item_t out_reg;
    lsqm_pkg::out_item_t out_next;

    // Memory interface
    logic [IDX_W-1:0]  rd_addr;
    logic [LINK_W-1:0] ram_rdata;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] wr_data;

    // Execute stage helpers
    logic [LINK_W-1:0] link_rd;
    logic [IDX_W-1:0]  slot_idx;
    logic [LINK_W-1:0] slot_link;
    logic              slot_ok;

    // Pick the entry to read: free head for acquire, item slot otherwise
    assign rd_addr = (req.func == lsqm_pkg::FUNC_ACQUIRE) ?
                     free_head_reg[IDX_W-1:0] : IDX_W'(req.slot);

    lsqm_ram #(
        .WIDTH (LINK_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (cmd.capture),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Hold the item and read context on capture; load the response on execute
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg    <= req;
            rd_addr_reg <= rd_addr;
            rd_vld_reg  <= vld_reg[rd_addr];
        end
        if (cmd.execute)
        begin
            out_reg <= out_next;
        end
    end

    // List state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= '0;
            queue_head_reg <= lsqm_pkg::END_LINK;
            queue_tail_reg <= lsqm_pkg::END_LINK;
            vld_reg        <= '0;
        end
        else
        begin
            free_head_reg  <= free_head_next;
            queue_head_reg <= queue_head_next;
            queue_tail_reg <= queue_tail_next;
            vld_reg        <= vld_next;
        end
    end

    // Unwritten entries read as their reset link
    assign link_rd   = rd_vld_reg ? ram_rdata : lsqm_pkg::reset_link(rd_addr_reg);
    assign slot_idx  = IDX_W'(item_reg.slot);
    assign slot_link = LINK_W'(item_reg.slot);
    assign slot_ok   = 32'(item_reg.slot) < 32'(SLOTS);

    // Operation decode and list update
    always_comb
    begin
        free_head_next     = free_head_reg;
        queue_head_next    = queue_head_reg;
        queue_tail_next    = queue_tail_reg;
        vld_next           = vld_reg;
        wr_en              = 1'b0;
        wr_addr            = slot_idx;
        wr_data            = lsqm_pkg::END_LINK;
        out_next.slot_out  = item_reg.slot;
        out_next.valid_res = 1'b0;

        unique case (item_reg.func)
            lsqm_pkg::FUNC_ACQUIRE:
            begin
                out_next.slot_out = '0;
                // Pop the free head and mark its link as end
                if (!lsqm_pkg::is_end(free_head_reg))
                begin
                    wr_en              = 1'b1;
                    wr_addr            = free_head_reg[IDX_W-1:0];
                    wr_data            = lsqm_pkg::END_LINK;
                    free_head_next     = link_rd;
                    out_next.slot_out  = lsqm_pkg::SLOT_W'(free_head_reg);
                    out_next.valid_res = 1'b1;
                end
            end
            lsqm_pkg::FUNC_COMMIT:
            begin
                // Append at the tail; first slot becomes head with an end link
                if (slot_ok)
                begin
                    out_next.valid_res = 1'b1;
                    wr_en              = 1'b1;
                    if (lsqm_pkg::is_end(queue_tail_reg))
                    begin
                        wr_addr         = slot_idx;
                        wr_data         = lsqm_pkg::END_LINK;
                        queue_head_next = slot_link;
                    end
                    else
                    begin
                        wr_addr = queue_tail_reg[IDX_W-1:0];
                        wr_data = slot_link;
                    end
                    queue_tail_next = slot_link;
                end
            end
            lsqm_pkg::FUNC_PEEK:
            begin
                out_next.slot_out = '0;
                if (!lsqm_pkg::is_end(queue_head_reg))
                begin
                    out_next.slot_out  = lsqm_pkg::SLOT_W'(queue_head_reg);
                    out_next.valid_res = 1'b1;
                end
            end
            lsqm_pkg::FUNC_RELEASE:
            begin
                // Unlink from either end, then push onto the free list
                if (slot_ok)
                begin
                    out_next.valid_res = 1'b1;
                    if (queue_head_reg == slot_link)
                    begin
                        queue_head_next = link_rd;
                    end
                    if (queue_tail_reg == slot_link)
                    begin
                        queue_tail_next = link_rd;
                    end
                    wr_en          = 1'b1;
                    wr_addr        = slot_idx;
                    wr_data        = free_head_reg;
                    free_head_next = slot_link;
                end
            end
            default:
            begin
                out_next.valid_res = 1'b0;
            end
        endcase

        // Only commit the update on execute
        if (!cmd.execute)
        begin
            free_head_next  = free_head_reg;
            queue_head_next = queue_head_reg;
            queue_tail_next = queue_tail_reg;
            wr_en           = 1'b0;
        end
        if (wr_en)
        begin
            vld_next[wr_addr] = 1'b1;
        end
    end

    assign rsp = out_reg;

endmodule

// ===== rtl/linked_slot_queue_manager.sv =====
// ----------------------------------------------------------------------------
// linked_slot_queue_manager
// Free list and committed queue of message slots kept in one link memory.
// ----------------------------------------------------------------------------
// Each request item is captured with its link read, then executed with its
// write back and the response load. No new item is taken until the last one
// executes, set by the registered link read and the write back that follows.
// A stalled response blocks at most one further item, which waits for it.
// Reset (rst_n low, asynchronous) restores the full free list and empty
// queue at once through per entry written flags; no clearing pass.
// ----------------------------------------------------------------------------
module linked_slot_queue_manager (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lsqm_pkg::in_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output lsqm_pkg::out_item_t rsp
);

    lsqm_pkg::cmd_t cmd;

    lsqm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    lsqm_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// ===== rtl/lsqm_checker.sv =====
// ----------------------------------------------------------------------------
// lsqm_checker
// Port level checks of the queue manager's timing, bound to the top level.
// ----------------------------------------------------------------------------
module lsqm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input lsqm_pkg::in_item_t  req,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input lsqm_pkg::out_item_t rsp
);

    // One item in flight: no new item right after one is taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken twice in a row");

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("response changed while stalled");

    // A new response only follows work with intake closed
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("response appeared without a request in work");

    // With the output free, a commit answers after capture and execute, echoing its slot
    a_commit_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && !rsp_valid && req.func == lsqm_pkg::FUNC_COMMIT)
        |=> ##1 (rsp_valid && rsp.valid_res && rsp.slot_out == $past(req.slot, 2)))
        else $error("commit response missing or wrong");

endmodule

bind linked_slot_queue_manager lsqm_checker u_lsqm_checker (.*);
